/* hdl/zoned_storage_zone_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Zone allocator assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ZONED_STORAGE_ZONE_ALLOCATOR_MACROS_SVH
`define ZONED_STORAGE_ZONE_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define ZSZA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define ZSZA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ZSZA_ASSERT_IMPLY(label, ante, cons, msg)
`define ZSZA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* hdl/zsza_pkg.sv */
// ----------------------------------------------------------------------------
// Zone allocator package
// Field widths, command and status codes, register indexes and shared types.
// ----------------------------------------------------------------------------
package zsza_pkg;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int CLS_W  = 3;
  localparam int CNT_W  = 4;
  localparam int ZIDX_W = 6;
  localparam int SECT_W = 30;
  localparam int STAT_W = 2;
  localparam int SPZ_W  = 25;
  localparam int NZC_W  = 7;

  // Stream packing
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;
  localparam int CLS_LSB    = 0;
  localparam int CNT_LSB    = CLS_LSB + CLS_W;
  localparam int ZIDX_LSB   = CNT_LSB + CNT_W;
  localparam int OLD_LSB    = ZIDX_LSB + ZIDX_W;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = SPZ_W;
  localparam logic [CFG_ADDR_W-1:0] REG_SPZ   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ZONES = 2'd1;

  // Parameter defaults
  localparam int NUM_ZONES_DEF   = 64;
  localparam int NUM_CLASSES_DEF = 5;
  localparam int MAX_RUN_DEF     = 8;

  // Register limits and reset values
  localparam logic [SPZ_W-1:0] SPZ_MIN   = 25'd8;
  localparam logic [SPZ_W-1:0] SPZ_MAX   = 25'd16777216;
  localparam logic [SPZ_W-1:0] SPZ_RESET = 25'd524288;
  localparam logic [NZC_W-1:0] NZ_RESET  = 7'd64;

  // Class tag of a zone in the free pool
  localparam logic [CLS_W-1:0] CLS_NONE = '0;

  // Free-zone search group size
  localparam int FFS_GRP = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_RESET = 2'd1,
    CMD_INVAL = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_OPEN_CHK,
    S_CLAIM,
    S_CLAIM_RD,
    S_APPEND,
    S_PHYS,
    S_DIV,
    S_INV_RD,
    S_DONE
  } state_t;

  // One zone table entry
  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [SPZ_W-1:0] fill;
    logic [SPZ_W-1:0] dead;
  } zone_entry_t;

endpackage

/* hdl/zsza_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module zsza_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/zsza_ffs.sv */
// ----------------------------------------------------------------------------
// Free zone search
// Two-stage registered find-first-set over the free-zone mask.
// ----------------------------------------------------------------------------
module zsza_ffs
  import zsza_pkg::*;
#(
  parameter int NUM_ZONES = NUM_ZONES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [NUM_ZONES-1:0]         free_mask,
  output logic                         found,
  output logic [$clog2(NUM_ZONES)-1:0] idx
);

  localparam int ZW   = $clog2(NUM_ZONES);
  localparam int NG   = (NUM_ZONES + FFS_GRP - 1) / FFS_GRP;
  localparam int PADW = NG * FFS_GRP;
  localparam int GW   = $clog2(FFS_GRP);

  logic [PADW-1:0] padded;
  logic [NG-1:0]   grp_any_r, grp_any_nxt;
  logic [GW-1:0]   grp_first_r [NG];
  logic [GW-1:0]   grp_first_nxt [NG];
  logic            found_r, found_nxt;
  logic [ZW-1:0]   idx_r, idx_nxt;

  assign padded = PADW'(free_mask);

  // Stage one: lowest free bit inside each group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any_nxt[g]   = |padded[g*FFS_GRP +: FFS_GRP];
      grp_first_nxt[g] = '0;
      for (int b = FFS_GRP - 1; b >= 0; b--) begin
        if (padded[g*FFS_GRP + b]) begin
          grp_first_nxt[g] = GW'(b);
        end
      end
    end
  end

  // Stage two: lowest group that has a free zone
  always_comb begin
    found_nxt = 1'b0;
    idx_nxt   = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        found_nxt = 1'b1;
        idx_nxt   = ZW'(g * FFS_GRP + int'(grp_first_r[g]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_any_r <= '0;
      found_r   <= 1'b0;
    end else begin
      grp_any_r <= grp_any_nxt;
      found_r   <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_first_r <= grp_first_nxt;
    idx_r       <= idx_nxt;
  end

  assign found = found_r;
  assign idx   = idx_r;

endmodule

/* hdl/zsza_div.sv */
// ----------------------------------------------------------------------------
// Zone number divider
// Restoring division of a sector number by the zone size, one quotient bit
// per cycle, with an up-front check for quotients beyond the zone range.
// ----------------------------------------------------------------------------
module zsza_div
  import zsza_pkg::*;
#(
  parameter int QW = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SECT_W-1:0] dividend,
  input  logic [SPZ_W-1:0]  divisor,
  output logic              done,
  output logic              over,
  output logic [QW-1:0]     quot
);

  localparam int SW   = SPZ_W + QW;
  localparam int EW   = (SECT_W > SW) ? SECT_W : SW;
  localparam int CNTW = $clog2(QW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [EW-1:0]   rem_r;
  logic [EW-1:0]   dsh_r;
  logic [QW-1:0]   quot_r;
  logic            over_r;
  logic            take;

  assign take = (rem_r >= dsh_r);

  // Iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder, shifted divisor and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= EW'(dividend);
      dsh_r  <= EW'(divisor) << (QW - 1);
      over_r <= (EW'(dividend) >= (EW'(divisor) << QW));
      quot_r <= '0;
    end else if (busy_r) begin
      if (take) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r  <= dsh_r >> 1;
      quot_r <= (quot_r << 1) | QW'(take);
    end
  end

  assign done = done_r;
  assign over = over_r;
  assign quot = quot_r;

endmodule

/* hdl/zoned_storage_zone_allocator.sv */
// ----------------------------------------------------------------------------
// Zone allocator for an append-only zoned device
// Per-zone class tag, write pointer and dead count in one zone table RAM,
// one open zone per class, lowest-free-zone claim and dead-sector charging.
//
//   Channel   Direction  Handshake            Contents
//   in_       slave      in_tvalid/in_tready  command item
//   out_      master     out_tvalid/out_tready result item
//   cfg_      slave      cfg_valid/cfg_ready  register index and write data
//
// One item is in flight at a time. Reset and rejected items finish after decode,
// appends pass the open-zone check or a claim and then the append and address
// steps, and invalidates wait on the divider before charging the entry. Per-entry
// valid bits clear the zone table at reset. A stalled output holds the item in
// the done state, and configuration is taken only while idle with no item offered.
// ----------------------------------------------------------------------------
`include "zoned_storage_zone_allocator_macros.svh"

module zoned_storage_zone_allocator
  import zsza_pkg::*;
#(
  parameter int NUM_ZONES       = NUM_ZONES_DEF,
  parameter int NUM_CLASSES     = NUM_CLASSES_DEF,
  parameter int MAX_RUN_SECTORS = MAX_RUN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // zone_class[2:0], sector_count[6:3], zone_index[12:7], old_sector[42:13]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd[1:0]
  input  logic [CMD_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // phys_sector[29:0], touched_zone[35:30], dead_count[60:36]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [STAT_W-1:0]     out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ZW  = $clog2(NUM_ZONES);
  localparam int NZW = $clog2(NUM_ZONES + 1);
  localparam int CW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int RW  = $clog2(MAX_RUN_SECTORS + 1);
  localparam int PW  = ZW + SPZ_W;
  localparam int EBW = $bits(zone_entry_t);
  localparam logic [NZW-1:0] NZ_EFF_RESET =
    (int'(NZ_RESET) > NUM_ZONES) ? NZW'(NUM_ZONES) : NZW'(NZ_RESET);

  // Control state
  state_t state_r, state_nxt;

  // Item fields
  cmd_t              cmd_r;
  logic [CLS_W-1:0]  cls_r;
  logic [RW-1:0]     nr_r;
  logic [ZIDX_W-1:0] zidx_r;
  logic [SECT_W-1:0] old_r;
  logic [CNT_W-1:0]  cnt_in;
  logic [RW-1:0]     nr_in;

  // Working entry
  logic [ZW-1:0]    z_r, z_nxt;
  logic [CLS_W-1:0] zcls_r, zcls_nxt;
  logic [SPZ_W-1:0] fill_r, fill_nxt;
  logic [SPZ_W-1:0] dead_r, dead_nxt;
  logic [PW-1:0]    prod_r, prod_nxt;

  // Result
  status_t           res_st_r, res_st_nxt;
  logic [SECT_W-1:0] res_phys_r, res_phys_nxt;
  logic [ZIDX_W-1:0] res_zone_r, res_zone_nxt;
  logic [SPZ_W-1:0]  res_dead_r, res_dead_nxt;

  // Zone bookkeeping
  logic [NUM_ZONES-1:0]   used_r, used_nxt;
  logic [NUM_ZONES-1:0]   vld_r;
  logic                   rd_vld_r;
  logic [ZW-1:0]          open_zone_r [NUM_CLASSES];
  logic [ZW-1:0]          open_zone_nxt [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] open_valid_r, open_valid_nxt;
  logic [NUM_ZONES-1:0]   free_mask;

  // Configuration
  logic [SPZ_W-1:0] spz_r;
  logic [NZW-1:0]   nz_r;
  logic [SPZ_W-1:0] spz_wr;
  logic [NZC_W-1:0] nz_raw;
  logic [NZW-1:0]   nz_wr;

  // Output register
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [STAT_W-1:0]     out_tuser_r;
  logic                  out_load;

  // Zone table RAM
  logic          ram_we, ram_re;
  logic [ZW-1:0] ram_waddr, ram_raddr;
  zone_entry_t   ram_wdata, ram_rdata, rd_entry;

  // Sub-unit links
  logic          ffs_found;
  logic [ZW-1:0] ffs_idx;
  logic          div_start, div_done, div_over;
  logic [ZW-1:0] div_q;

  logic [CW-1:0]    cls_idx;
  logic             cls_bad;
  logic [SPZ_W-1:0] dead_inc;

  // ---------------------------------------------------------------------------
  // Sub-units
  // ---------------------------------------------------------------------------
  zsza_ram #(
    .WIDTH (EBW),
    .DEPTH (NUM_ZONES)
  ) u_zone_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  zsza_ffs #(
    .NUM_ZONES (NUM_ZONES)
  ) u_ffs (
    .clk       (clk),
    .rst_n     (rst_n),
    .free_mask (free_mask),
    .found     (ffs_found),
    .idx       (ffs_idx)
  );

  zsza_div #(
    .QW (ZW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (old_r),
    .divisor  (spz_r),
    .done     (div_done),
    .over     (div_over),
    .quot     (div_q)
  );

  // ---------------------------------------------------------------------------
  // Configuration registers, clamped on write
  // ---------------------------------------------------------------------------
  // Take a write only while idle and no item is offered, so the free-zone
  // search has settled on the new pool size before the next claim
  assign cfg_ready = rst_n && (state_r == S_IDLE) && !in_tvalid;
  assign nz_raw    = cfg_wdata[NZC_W-1:0];

  always_comb begin
    if (cfg_wdata < SPZ_MIN) begin
      spz_wr = SPZ_MIN;
    end else if (cfg_wdata > SPZ_MAX) begin
      spz_wr = SPZ_MAX;
    end else begin
      spz_wr = cfg_wdata;
    end
    if (nz_raw == '0) begin
      nz_wr = NZW'(1);
    end else if (int'(nz_raw) > NUM_ZONES) begin
      nz_wr = NZW'(NUM_ZONES);
    end else begin
      nz_wr = NZW'(nz_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spz_r <= SPZ_RESET;
      nz_r  <= NZ_EFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_SPZ:   spz_r <= spz_wr;
        REG_ZONES: nz_r  <= nz_wr;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Item capture with run-length clamp
  // ---------------------------------------------------------------------------
  assign cnt_in = in_tdata[CNT_LSB +: CNT_W];

  always_comb begin
    if (cnt_in == '0) begin
      nr_in = RW'(1);
    end else if (int'(cnt_in) > MAX_RUN_SECTORS) begin
      nr_in = RW'(MAX_RUN_SECTORS);
    end else begin
      nr_in = RW'(cnt_in);
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r  <= cmd_t'(in_tuser);
      cls_r  <= in_tdata[CLS_LSB +: CLS_W];
      nr_r   <= nr_in;
      zidx_r <= in_tdata[ZIDX_LSB +: ZIDX_W];
      old_r  <= in_tdata[OLD_LSB +: SECT_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Derived values
  // ---------------------------------------------------------------------------
  assign cls_idx  = CW'(cls_r);
  assign cls_bad  = (cls_r == CLS_NONE) || (int'(cls_r) >= NUM_CLASSES);
  // Entries never written read as the cleared state
  assign rd_entry = rd_vld_r ? ram_rdata : '0;
  assign dead_inc = (rd_entry.dead < spz_r) ? rd_entry.dead + SPZ_W'(1) : rd_entry.dead;

  // Free zones among the managed range
  always_comb begin
    for (int z = 0; z < NUM_ZONES; z++) begin
      free_mask[z] = !used_r[z] && (z < int'(nz_r));
    end
  end

  // ---------------------------------------------------------------------------
  // Command sequencer: next state and table accesses
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    z_nxt          = z_r;
    zcls_nxt       = zcls_r;
    fill_nxt       = fill_r;
    dead_nxt       = dead_r;
    prod_nxt       = prod_r;
    res_st_nxt     = res_st_r;
    res_phys_nxt   = res_phys_r;
    res_zone_nxt   = res_zone_r;
    res_dead_nxt   = res_dead_r;
    used_nxt       = used_r;
    open_zone_nxt  = open_zone_r;
    open_valid_nxt = open_valid_r;
    ram_we         = 1'b0;
    ram_waddr      = z_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = z_r;
    div_start      = 1'b0;
    in_tready      = 1'b0;
    out_load       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        // Hold off items while reset is applied
        in_tready = rst_n;
        if (in_tvalid && in_tready) begin
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        // Start from the rejected result; later states overwrite it
        res_st_nxt   = ST_RANGE;
        res_phys_nxt = '0;
        res_zone_nxt = '0;
        res_dead_nxt = '0;
        state_nxt    = S_DONE;
        unique case (cmd_r)
          CMD_ALLOC: begin
            if (cls_bad) begin
              res_st_nxt = ST_RANGE;
            end else if (int'(nr_r) > int'(spz_r)) begin
              res_st_nxt = ST_NOSPACE;
            end else if (open_valid_r[cls_idx]) begin
              z_nxt     = open_zone_r[cls_idx];
              ram_re    = 1'b1;
              ram_raddr = open_zone_r[cls_idx];
              state_nxt = S_OPEN_CHK;
            end else begin
              state_nxt = S_CLAIM;
            end
          end
          CMD_RESET: begin
            if (int'(zidx_r) < int'(nz_r)) begin
              // Free the zone and close any class that has it open
              ram_we             = 1'b1;
              ram_waddr          = ZW'(zidx_r);
              ram_wdata          = '0;
              used_nxt[ZW'(zidx_r)] = 1'b0;
              for (int c = 0; c < NUM_CLASSES; c++) begin
                if (open_valid_r[c] && (open_zone_r[c] == ZW'(zidx_r))) begin
                  open_valid_nxt[c] = 1'b0;
                end
              end
              res_st_nxt   = ST_OK;
              res_zone_nxt = zidx_r;
            end
          end
          CMD_INVAL: begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
          default: begin
            res_st_nxt = ST_RANGE;
          end
        endcase
      end

      S_OPEN_CHK: begin
        if ((int'(rd_entry.fill) + int'(nr_r)) > int'(spz_r)) begin
          state_nxt = S_CLAIM;
        end else begin
          zcls_nxt  = rd_entry.cls;
          fill_nxt  = rd_entry.fill;
          dead_nxt  = rd_entry.dead;
          state_nxt = S_APPEND;
        end
      end

      S_CLAIM: begin
        if (!ffs_found) begin
          res_st_nxt = ST_NOSPACE;
          state_nxt  = S_DONE;
        end else begin
          z_nxt     = ffs_idx;
          ram_re    = 1'b1;
          ram_raddr = ffs_idx;
          state_nxt = S_CLAIM_RD;
        end
      end

      S_CLAIM_RD: begin
        // Tag the zone, rewind it, keep its dead count and open it
        zcls_nxt                = cls_r;
        fill_nxt                = '0;
        dead_nxt                = rd_entry.dead;
        used_nxt[z_r]           = 1'b1;
        open_zone_nxt[cls_idx]  = z_r;
        open_valid_nxt[cls_idx] = 1'b1;
        state_nxt               = S_APPEND;
      end

      S_APPEND: begin
        ram_we         = 1'b1;
        ram_wdata.cls  = zcls_r;
        ram_wdata.fill = fill_r + SPZ_W'(nr_r);
        ram_wdata.dead = dead_r;
        prod_nxt       = PW'(z_r) * PW'(spz_r);
        state_nxt      = S_PHYS;
      end

      S_PHYS: begin
        res_st_nxt   = ST_OK;
        res_phys_nxt = SECT_W'(prod_r + PW'(fill_r));
        res_zone_nxt = ZIDX_W'(z_r);
        res_dead_nxt = dead_r;
        state_nxt    = S_DONE;
      end

      S_DIV: begin
        if (div_done) begin
          if (div_over || (int'(div_q) >= int'(nz_r))) begin
            state_nxt = S_DONE;
          end else begin
            z_nxt     = div_q;
            ram_re    = 1'b1;
            ram_raddr = div_q;
            state_nxt = S_INV_RD;
          end
        end
      end

      S_INV_RD: begin
        // Charge one dead sector, saturating at the zone size
        ram_we         = 1'b1;
        ram_wdata.cls  = rd_entry.cls;
        ram_wdata.fill = rd_entry.fill;
        ram_wdata.dead = dead_inc;
        res_st_nxt     = ST_OK;
        res_zone_nxt   = ZIDX_W'(z_r);
        res_dead_nxt   = dead_inc;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer and bookkeeping registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= '0;
      vld_r        <= '0;
      open_valid_r <= '0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      open_valid_r <= open_valid_nxt;
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    z_r         <= z_nxt;
    zcls_r      <= zcls_nxt;
    fill_r      <= fill_nxt;
    dead_r      <= dead_nxt;
    prod_r      <= prod_nxt;
    res_st_r    <= res_st_nxt;
    res_phys_r  <= res_phys_nxt;
    res_zone_r  <= res_zone_nxt;
    res_dead_r  <= res_dead_nxt;
    open_zone_r <= open_zone_nxt;
    if (ram_re) begin
      rd_vld_r <= vld_r[ram_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= OUT_DATA_W'({res_dead_r, res_zone_r, res_phys_r});
      out_tuser_r <= res_st_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ZSZA_ASSERT_NEXT(a_done_holds, (state_r == S_DONE) && out_tvalid_r && !out_tready, state_r == S_DONE, "finished item dropped while output stalled")
  `ZSZA_ASSERT_IMPLY(a_div_in_wait, div_done, state_r == S_DIV, "divider finished outside its wait state")
  `ZSZA_ASSERT_IMPLY(a_no_idle_write, ram_we, (state_r != S_IDLE) && (state_r != S_DONE), "zone table written outside a command")

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_open_chk
    `ZSZA_ASSERT_IMPLY(a_open_used, open_valid_r[c], used_r[open_zone_r[c]], "open zone is not marked as claimed")
  end

endmodule
